/* design/clause_resolution_engine_assert.svh */
// assertion macros used by the clause resolution engine sequencer
// all of them sample on aclk and are disabled while aresetn is low
`ifndef CLAUSE_RESOLUTION_ENGINE_ASSERT_SVH
`define CLAUSE_RESOLUTION_ENGINE_ASSERT_SVH

// same-cycle implication
`define CRE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("clause resolution engine: same-cycle check failed");

// next-cycle implication
`define CRE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("clause resolution engine: next-cycle check failed");

`endif

/* design/cre_pkg.sv */
// ----------------------------------------------------------------------------
// cre_pkg
// Shared constants, types and helper functions of the clause resolution engine.
// ----------------------------------------------------------------------------
`default_nettype none

package cre_pkg;

    localparam int NUM_VARS    = 64;
    localparam int STORE_DEPTH = 64;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int PC_W        = 7;
    localparam int LEN_W       = 8;

    localparam logic [63:0] VAR_MASK =
        (NUM_VARS >= 64) ? {64{1'b1}} : ((64'd1 << NUM_VARS) - 64'd1);

    localparam logic [63:0] M1  = 64'h5555555555555555;
    localparam logic [63:0] M2  = 64'h3333333333333333;
    localparam logic [63:0] M4  = 64'h0f0f0f0f0f0f0f0f;
    localparam logic [63:0] M8  = 64'h00ff00ff00ff00ff;
    localparam logic [63:0] M16 = 64'h0000ffff0000ffff;
    localparam logic [63:0] M32 = 64'h00000000ffffffff;

    typedef enum logic [2:0] {
        STAT_RESOLVENT = 3'd0,
        STAT_TAUTOLOGY = 3'd1,
        STAT_DUPLICATE = 3'd2,
        STAT_NONE      = 3'd3,
        STAT_FULL      = 3'd4,
        STAT_EMPTY     = 3'd5,
        STAT_CLEARED   = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DUP_START,
        S_DUP_RD,
        S_DUP_CMP,
        S_CHK_FULL,
        S_RS_RD,
        S_RS_EV,
        S_RS_DEC,
        S_FIN,
        S_EMIT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic             load_in;
        logic             rd_en;
        logic             wr_en;
        logic [IDX_W-1:0] addr;
        logic             eval;
        logic             push;
        logic             fin;
        logic             emit_code;
        status_t          code;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic taut;
        logic dup_eq;
        logic res_ok;
        logic res_empty;
        logic out_free;
        logic pend_valid;
    } dp_stat_t;

    // swar population count
    function automatic logic [PC_W-1:0] popcount64(input logic [63:0] v);
        logic [63:0] t;
        t = (v & M1) + ((v >> 1) & M1);
        t = (t & M2) + ((t >> 2) & M2);
        t = (t & M4) + ((t >> 4) & M4);
        t = (t & M8) + ((t >> 8) & M8);
        t = (t & M16) + ((t >> 16) & M16);
        t = (t & M32) + (t >> 32);
        return t[PC_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* design/cre_datapath.sv */
// ----------------------------------------------------------------------------
// cre_datapath
// Clause store, resolution evaluation, pending resolvent and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cre_datapath (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cre_pkg::dp_cmd_t  cmd,
    output cre_pkg::dp_stat_t      stat,
    input  wire logic [63:0]       s_clause_pos,
    input  wire logic [63:0]       s_clause_neg,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [63:0]            m_res_pos,
    output logic [63:0]            m_res_neg,
    output logic [2:0]             m_status,
    output logic                   m_is_last
);
    import cre_pkg::*;

    logic [63:0] mem_pos [STORE_DEPTH];
    logic [63:0] mem_neg [STORE_DEPTH];

    logic [63:0]      np_reg, nn_reg;
    logic [LEN_W-1:0] newlen_reg;
    logic [63:0]      rd_pos_reg, rd_neg_reg;
    logic [63:0]      rp_reg, rn_reg;
    logic             single_reg, taut_reg;
    logic [LEN_W-1:0] oldlen_reg, reslen_reg;
    logic [63:0]      pend_pos_reg, pend_neg_reg;
    status_t          pend_st_reg;
    logic             pend_valid_reg;
    logic             out_valid_reg;
    logic [63:0]      out_pos_reg, out_neg_reg;
    status_t          out_st_reg;
    logic             out_last_reg;

    logic [63:0]      in_p, in_n;
    logic [63:0]      c1, c2, cc, rp, rn;
    logic [LEN_W-1:0] big_len;
    logic             out_free;

    // masked input
    assign in_p = s_clause_pos & VAR_MASK;
    assign in_n = s_clause_neg & VAR_MASK;

    // latch offered clause and its length
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            np_reg     <= in_p;
            nn_reg     <= in_n;
            newlen_reg <= LEN_W'(popcount64(in_p)) + LEN_W'(popcount64(in_n));
        end
    end

    // clause store
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem_pos[cmd.addr] <= np_reg;
            mem_neg[cmd.addr] <= nn_reg;
        end
        if (cmd.rd_en) begin
            rd_pos_reg <= mem_pos[cmd.addr];
            rd_neg_reg <= mem_neg[cmd.addr];
        end
    end

    // resolvent of stored clause and new clause
    assign c1 = rd_pos_reg & nn_reg;
    assign c2 = rd_neg_reg & np_reg;
    assign cc = c1 | c2;
    assign rp = (rd_pos_reg & ~c1) | (np_reg & ~c2);
    assign rn = (rd_neg_reg & ~c2) | (nn_reg & ~c1);

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            rp_reg     <= rp;
            rn_reg     <= rn;
            single_reg <= (cc != 64'd0) && ((cc & (cc - 64'd1)) == 64'd0);
            taut_reg   <= |(rp & rn);
            oldlen_reg <= LEN_W'(popcount64(rd_pos_reg)) + LEN_W'(popcount64(rd_neg_reg));
            reslen_reg <= LEN_W'(popcount64(rp)) + LEN_W'(popcount64(rn));
        end
    end

    assign big_len = (oldlen_reg > newlen_reg) ? oldlen_reg : newlen_reg;
    assign out_free = !out_valid_reg;

    // status to controller
    always_comb begin
        stat.taut       = |(np_reg & nn_reg);
        stat.dup_eq     = (rd_pos_reg == np_reg) && (rd_neg_reg == nn_reg);
        stat.res_ok     = single_reg && !taut_reg && (reslen_reg <= big_len);
        stat.res_empty  = (rp_reg == 64'd0) && (rn_reg == 64'd0);
        stat.out_free   = out_free;
        stat.pend_valid = pend_valid_reg;
    end

    // pending resolvent, held until it is known whether it is the last
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (cmd.push) begin
            pend_valid_reg <= 1'b1;
        end else if (cmd.fin) begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            pend_pos_reg <= rp_reg;
            pend_neg_reg <= rn_reg;
            pend_st_reg  <= stat.res_empty ? STAT_EMPTY : STAT_RESOLVENT;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit_code || cmd.fin || (cmd.push && pend_valid_reg)) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_code) begin
            out_pos_reg  <= 64'd0;
            out_neg_reg  <= 64'd0;
            out_st_reg   <= cmd.code;
            out_last_reg <= 1'b1;
        end else if (cmd.fin) begin
            out_pos_reg  <= pend_valid_reg ? pend_pos_reg : 64'd0;
            out_neg_reg  <= pend_valid_reg ? pend_neg_reg : 64'd0;
            out_st_reg   <= pend_valid_reg ? pend_st_reg : STAT_NONE;
            out_last_reg <= 1'b1;
        end else if (cmd.push && pend_valid_reg) begin
            out_pos_reg  <= pend_pos_reg;
            out_neg_reg  <= pend_neg_reg;
            out_st_reg   <= pend_st_reg;
            out_last_reg <= 1'b0;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_res_pos = out_pos_reg;
    assign m_res_neg = out_neg_reg;
    assign m_status  = out_st_reg;
    assign m_is_last = out_last_reg;

endmodule

`default_nettype wire

/* design/cre_ctrl.sv */
// ----------------------------------------------------------------------------
// cre_ctrl
// Sequencer: duplicate scan, store, newest-first resolution, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module cre_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_req_type,
    output cre_pkg::dp_cmd_t        cmd,
    input  wire cre_pkg::dp_stat_t  stat
);
    import cre_pkg::*;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    status_t          code_reg, code_next;
    logic             accept;
    logic [CNT_W-1:0] last_idx;

    assign accept   = s_valid && s_ready;
    assign last_idx = count_reg - CNT_W'(1);

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            code_reg  <= STAT_NONE;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            code_reg  <= code_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        code_next  = code_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_req_type) begin
                        count_next = '0;
                        code_next  = STAT_CLEARED;
                        state_next = S_EMIT;
                    end else begin
                        state_next = S_DUP_START;
                    end
                end
            end
            S_DUP_START: begin
                idx_next = '0;
                if (stat.taut) begin
                    code_next  = STAT_TAUTOLOGY;
                    state_next = S_EMIT;
                end else if (count_reg == '0) begin
                    state_next = S_CHK_FULL;
                end else begin
                    state_next = S_DUP_RD;
                end
            end
            S_DUP_RD: begin
                state_next = S_DUP_CMP;
            end
            S_DUP_CMP: begin
                if (stat.dup_eq) begin
                    code_next  = STAT_DUPLICATE;
                    state_next = S_EMIT;
                end else if (idx_reg == last_idx[IDX_W-1:0]) begin
                    state_next = S_CHK_FULL;
                end else begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_DUP_RD;
                end
            end
            S_CHK_FULL: begin
                if (count_reg == CNT_W'(STORE_DEPTH)) begin
                    code_next  = STAT_FULL;
                    state_next = S_EMIT;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                    if (count_reg == '0) begin
                        state_next = S_FIN;
                    end else begin
                        idx_next   = last_idx[IDX_W-1:0];
                        state_next = S_RS_RD;
                    end
                end
            end
            S_RS_RD: begin
                state_next = S_RS_EV;
            end
            S_RS_EV: begin
                state_next = S_RS_DEC;
            end
            S_RS_DEC: begin
                if (stat.res_ok && stat.pend_valid && !stat.out_free) begin
                    state_next = S_RS_DEC;
                end else if (stat.res_ok && stat.res_empty) begin
                    state_next = S_FIN;
                end else if (idx_reg == '0) begin
                    state_next = S_FIN;
                end else begin
                    idx_next   = idx_reg - IDX_W'(1);
                    state_next = S_RS_RD;
                end
            end
            S_FIN: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath commands
    always_comb begin
        s_ready       = (state_reg == S_IDLE);
        cmd.load_in   = accept;
        cmd.rd_en     = 1'b0;
        cmd.wr_en     = 1'b0;
        cmd.addr      = idx_reg;
        cmd.eval      = 1'b0;
        cmd.push      = 1'b0;
        cmd.fin       = 1'b0;
        cmd.emit_code = 1'b0;
        cmd.code      = code_reg;
        case (state_reg)
            S_DUP_RD: begin
                cmd.rd_en = 1'b1;
            end
            S_RS_RD: begin
                cmd.rd_en = 1'b1;
            end
            S_CHK_FULL: begin
                cmd.addr  = count_reg[IDX_W-1:0];
                cmd.wr_en = (count_reg != CNT_W'(STORE_DEPTH));
            end
            S_RS_EV: begin
                cmd.eval = 1'b1;
            end
            S_RS_DEC: begin
                cmd.push = stat.res_ok && (stat.out_free || !stat.pend_valid);
            end
            S_FIN: begin
                cmd.fin = stat.out_free;
            end
            S_EMIT: begin
                cmd.emit_code = stat.out_free;
            end
            default: begin
                cmd.load_in = accept;
            end
        endcase
    end

    `include "clause_resolution_engine_assert.svh"

    `CRE_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(STORE_DEPTH))
    `CRE_ASSERT_IMP(a_write_room, cmd.wr_en, count_reg < CNT_W'(STORE_DEPTH))
    `CRE_ASSERT_NXT(a_clear_count, accept && s_req_type, count_reg == '0)
    `CRE_ASSERT_NXT(a_eval_then_dec, state_reg == S_RS_EV, state_reg == S_RS_DEC)

endmodule

`default_nettype wire

/* design/clause_resolution_engine.sv */
// ----------------------------------------------------------------------------
// clause_resolution_engine
// Binary resolution of each new clause against the stored clauses.
//
//   channel  direction  ports                                  handshake
//   s_       in         s_req_type s_clause_pos s_clause_neg    s_valid/s_ready
//   m_       out        m_res_pos m_res_neg m_status m_is_last  m_valid/m_ready
//
// an add transaction scans the store for a duplicate, reading one entry
// and then comparing it, and each resolution step is read, evaluate,
// decide on the single store port.
// clear and tautology transactions go straight to their status result.
// reset empties the store count; stored entries need no clearing.
// a stalled result channel holds the sequencer whenever a result is ready
// to leave while the output register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module clause_resolution_engine (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_req_type,
    input  wire logic [63:0] s_clause_pos,
    input  wire logic [63:0] s_clause_neg,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_res_pos,
    output logic [63:0]      m_res_neg,
    output logic [2:0]       m_status,
    output logic             m_is_last
);
    import cre_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer
    cre_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .cmd        (cmd),
        .stat       (stat)
    );

    // store and evaluation
    cre_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_clause_pos (s_clause_pos),
        .s_clause_neg (s_clause_neg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_res_pos    (m_res_pos),
        .m_res_neg    (m_res_neg),
        .m_status     (m_status),
        .m_is_last    (m_is_last)
    );

endmodule

`default_nettype wire

/* test/tb_clause_resolution_engine.sv */
// ----------------------------------------------------------------------------
// tb_clause_resolution_engine
// Self-checking bench for the clause resolution engine. A local model of the
// clause store predicts every result of each accepted transaction; results
// are compared field by field in order. Directed tests cover clear,
// tautology, duplicate, empty resolvent, the literal length rule and a full
// store. They are followed by random clause sequences, mostly over the low seven variables.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_clause_resolution_engine;
    import cre_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_OUT = 64;

    typedef struct {
        logic [63:0] rpos;
        logic [63:0] rneg;
        status_t     st;
        logic        last;
    } outcome_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_req_type;
    logic [63:0] s_clause_pos;
    logic [63:0] s_clause_neg;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_res_pos;
    logic [63:0] m_res_neg;
    logic [2:0]  m_status;
    logic        m_is_last;

    // local copy of the clause store
    logic [63:0] clause_p[STORE_DEPTH];
    logic [63:0] clause_n[STORE_DEPTH];
    int          clause_cnt;

    outcome_t    pending_q[$];
    int          mismatches;
    bit          steady;

    clause_resolution_engine u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_clause_pos (s_clause_pos),
        .s_clause_neg (s_clause_neg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_res_pos    (m_res_pos),
        .m_res_neg    (m_res_neg),
        .m_status     (m_status),
        .m_is_last    (m_is_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void push_outcome(logic [63:0] p, logic [63:0] n, status_t st,
                                         logic last);
        outcome_t o;
        o.rpos = p;
        o.rneg = n;
        o.st   = st;
        o.last = last;
        pending_q.push_back(o);
    endfunction

    // resolve one transaction against the local store
    function automatic void resolve_clause(logic req, logic [63:0] cp, logic [63:0] cn);
        logic [63:0] np, nn, op, on, c1, c2, c, rp, rn;
        int          newlen, oldlen, big, emitted;
        np = cp & VAR_MASK;
        nn = cn & VAR_MASK;
        emitted = 0;
        if (req) begin
            clause_cnt = 0;
            push_outcome('0, '0, STAT_CLEARED, 1'b1);
            return;
        end
        if ((np & nn) != '0) begin
            push_outcome('0, '0, STAT_TAUTOLOGY, 1'b1);
            return;
        end
        for (int i = 0; i < clause_cnt; i++) begin
            if (clause_p[i] == np && clause_n[i] == nn) begin
                push_outcome('0, '0, STAT_DUPLICATE, 1'b1);
                return;
            end
        end
        if (clause_cnt >= STORE_DEPTH) begin
            push_outcome('0, '0, STAT_FULL, 1'b1);
            return;
        end
        clause_p[clause_cnt] = np;
        clause_n[clause_cnt] = nn;
        clause_cnt++;
        newlen = $countones(np) + $countones(nn);
        // newest older clause first
        for (int i = clause_cnt - 2; i >= 0 && emitted < MAX_OUT; i--) begin
            op = clause_p[i];
            on = clause_n[i];
            c1 = op & nn;
            c2 = on & np;
            c  = c1 | c2;
            if ($countones(c) != 1) continue;
            rp = (op & ~c1) | (np & ~c2);
            rn = (on & ~c2) | (nn & ~c1);
            if ((rp & rn) != '0) continue;
            oldlen = $countones(op) + $countones(on);
            big = (oldlen > newlen) ? oldlen : newlen;
            if ($countones(rp) + $countones(rn) > big) continue;
            if (emitted > 0) pending_q[$].last = 1'b0;
            if (rp == '0 && rn == '0) begin
                push_outcome('0, '0, STAT_EMPTY, 1'b1);
                return;
            end
            push_outcome(rp, rn, STAT_RESOLVENT, 1'b1);
            emitted++;
        end
        if (emitted == 0) push_outcome('0, '0, STAT_NONE, 1'b1);
    endfunction

    // result channel: random backpressure and in-order compare
    always @(posedge aclk) begin
        outcome_t o;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 22);
            if (m_valid && m_ready) begin
                if (pending_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: pos=%h neg=%h st=%0d last=%0b",
                                 m_res_pos, m_res_neg, m_status, m_is_last);
                end else begin
                    o = pending_q.pop_front();
                    if (m_res_pos !== o.rpos || m_res_neg !== o.rneg ||
                        m_status !== o.st || m_is_last !== o.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %h %h %0d %0b got %h %h %0d %0b",
                                     o.rpos, o.rneg, o.st, o.last,
                                     m_res_pos, m_res_neg, m_status, m_is_last);
                    end
                end
            end
        end
    end

    // one transaction on the request channel, then an optional gap
    task automatic send_req(logic req, logic [63:0] cp, logic [63:0] cn);
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_clause_pos <= cp;
        s_clause_neg <= cn;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        resolve_clause(req, cp, cn);
        if (!steady && $urandom_range(0, 99) < 22) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic add_clause(logic [63:0] cp, logic [63:0] cn);
        send_req(1'b0, cp, cn);
    endtask

    task automatic clear_store();
        send_req(1'b1, $urandom_range(0, 1) ? '1 : '0, {$urandom, $urandom});
    endtask

    // hold the request channel until every result has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // random clause over the low variables, sometimes touching a high one
    function automatic void rand_clause(output logic [63:0] cp, output logic [63:0] cn);
        int nv, r, hb;
        cp = '0;
        cn = '0;
        nv = $urandom_range(3, 7);
        for (int v = 0; v < nv; v++) begin
            r = $urandom_range(0, 3);
            if (r == 1) cp[v] = 1'b1;
            else if (r == 2) cn[v] = 1'b1;
        end
        if ($urandom_range(0, 7) == 0) begin
            hb = $urandom_range(8, 63);
            if ($urandom_range(0, 1)) cp[hb] = 1'b1;
            else cn[hb] = 1'b1;
        end
    endfunction

    task automatic test_basic_cases();
        clear_store();
        add_clause(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
        add_clause('1, '1);
        add_clause(64'h1, '0);
        add_clause(64'h1, '0);
        add_clause('0, 64'h1);
        clear_store();
        add_clause('0, '0);
        add_clause('0, '0);
        wait_drained();
    endtask

    task automatic test_resolution_rules();
        clear_store();
        add_clause(64'h3, '0);
        add_clause(64'h4, 64'h1);
        add_clause(64'h8000_0000_0000_0000, 64'h2);
        add_clause('0, 64'h3);
        add_clause(64'h7, '0);
        add_clause(64'h18, 64'h1);
        add_clause('1, '0);
        add_clause('0, 64'hffff_ffff_ffff_fffe);
        add_clause('0, 64'h8000_0000_0000_0000);
        wait_drained();
    endtask

    task automatic test_full_store();
        clear_store();
        for (int i = 0; i < STORE_DEPTH; i++) add_clause(64'h1 << i, '0);
        add_clause(64'h1, '0);
        add_clause(64'h3, '0);
        add_clause('0, 64'h5);
        clear_store();
        wait_drained();
    endtask

    task automatic test_random_sequences();
        logic [63:0] cp, cn;
        int          r;
        for (int n = 0; n < 24; n++) begin
            steady = (n >= 4 && n < 16);
            if (n == 18) wait_drained();
            r = $urandom_range(0, 99);
            if (r < 5) begin
                clear_store();
            end else if (r < 15) begin
                add_clause({$urandom, $urandom}, {$urandom, $urandom});
            end else begin
                rand_clause(cp, cn);
                add_clause(cp, cn);
            end
        end
        steady = 1'b0;
        wait_drained();
    endtask

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_req_type   = 1'b0;
        s_clause_pos = '0;
        s_clause_neg = '0;
        m_ready      = 1'b0;
        clause_cnt   = 0;
        mismatches   = 0;
        steady       = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_basic_cases();
        test_resolution_rules();
        test_full_store();
        test_random_sequences();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && pending_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+design
design/cre_pkg.sv
design/cre_datapath.sv
design/cre_ctrl.sv
design/clause_resolution_engine.sv
test/tb_clause_resolution_engine.sv
